// ===== src/bfip_pkg.sv =====
// Shared types, constants and helper functions for the beacon frame info parser.
package bfip_pkg;

  localparam int NAME_BYTES = 32;
  localparam int NAME_IDX_W = $clog2(NAME_BYTES);
  localparam int NAME_LEN_W = NAME_IDX_W + 1;
  localparam int POS_W      = 12;

  localparam logic [POS_W-1:0] POS_MAX    = 12'd4095;
  localparam logic [POS_W-1:0] MAX_FRAME  = 12'd2048;
  localparam logic [POS_W-1:0] MIN_FRAME  = 12'd36;
  localparam logic [POS_W-1:0] LAST_MIN   = 12'd35;   // last byte position of a minimum frame
  localparam logic [POS_W-1:0] ADDR_FIRST = 12'd16;
  localparam logic [POS_W-1:0] ADDR_LAST  = 12'd21;
  localparam logic [POS_W-1:0] PRIV_POS   = 12'd34;

  localparam logic [7:0] PRIV_MASK  = 8'h10;
  localparam logic [3:0] SUB_BEACON = 4'd8;
  localparam logic [3:0] SUB_PROBE  = 4'd5;

  localparam logic [7:0] TAG_SSID   = 8'd0;
  localparam logic [7:0] TAG_RSN    = 8'd48;
  localparam logic [7:0] TAG_VENDOR = 8'd221;
  localparam logic [7:0] VENDOR_MIN = 8'd4;

  typedef enum logic [2:0] {
    AUTH_OPEN = 3'd0,
    AUTH_WEP  = 3'd1,
    AUTH_WPA  = 3'd2,
    AUTH_WPA2 = 3'd3,
    AUTH_BOTH = 3'd4
  } auth_t;

  typedef logic [NAME_BYTES-1:0][7:0] name_t;

  // Frame summary handed from the parser to the result emitter.
  typedef struct packed {
    name_t              name;
    logic [47:0]        addr;
    logic signed [7:0]  signal;
    logic [3:0]         channel;
    auth_t              auth;
  } snap_t;

  // WPA vendor prefix 00 50 F2 01
  function automatic logic [7:0] wpa_oui(input logic [1:0] idx);
    logic [7:0] v;
    case (idx)
      2'd0:    v = 8'h00;
      2'd1:    v = 8'h50;
      2'd2:    v = 8'hF2;
      2'd3:    v = 8'h01;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // Position of the first zero byte, NAME_BYTES if none. Two-level priority search.
  function automatic logic [NAME_LEN_W-1:0] name_len(input name_t nm);
    logic [3:0] has;
    logic [2:0] idx [4];
    logic [NAME_LEN_W-1:0] r;
    for (int g = 0; g < 4; g++) begin
      has[g] = 1'b0;
      idx[g] = 3'd0;
      for (int j = 7; j >= 0; j--) begin
        if (nm[g*8+j] == 8'd0) begin
          has[g] = 1'b1;
          idx[g] = 3'(j);
        end
      end
    end
    r = NAME_LEN_W'(NAME_BYTES);
    for (int g = 3; g >= 0; g--) begin
      if (has[g]) begin
        r = {1'b0, 2'(g), idx[g]};
      end
    end
    return r;
  endfunction

endpackage

// ===== src/bfip_in_if.sv =====
// Input channel: one frame byte per word with frame side info.
interface bfip_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        data_byte;
  logic              frame_end;
  logic              mgmt_frame;
  logic signed [7:0] signal_dbm;
  logic [3:0]        radio_channel;

  modport source (output valid, data_byte, frame_end, mgmt_frame, signal_dbm, radio_channel,
                  input ready);
  modport sink   (input valid, data_byte, frame_end, mgmt_frame, signal_dbm, radio_channel,
                  output ready);
endinterface

// ===== src/bfip_out_if.sv =====
// Result channel: one SSID byte per word with the frame summary.
interface bfip_out_if;
  logic              valid;
  logic              ready;
  logic [47:0]       station_addr;
  logic signed [7:0] out_signal;
  logic [3:0]        out_channel;
  logic [2:0]        auth_class;
  logic [5:0]        name_length;
  logic [4:0]        name_index;
  logic [7:0]        name_byte;
  logic              run_last;

  modport source (output valid, station_addr, out_signal, out_channel, auth_class,
                  name_length, name_index, name_byte, run_last, input ready);
  modport sink   (input valid, station_addr, out_signal, out_channel, auth_class,
                  name_length, name_index, name_byte, run_last, output ready);
endinterface

// ===== src/bfip_parser.sv =====
// Byte parser: input register, header capture and tagged element walk.
module bfip_parser (
  input  logic           clk,
  input  logic           rst_n,
  bfip_in_if.sink        in_ch,
  input  logic           emit_busy,
  output logic           snap_load,
  output bfip_pkg::snap_t snap
);
  import bfip_pkg::*;

  typedef enum logic [1:0] {PH_ID, PH_LEN, PH_BODY} phase_t;

  typedef struct packed {
    logic priv;
    logic rsn;
    logic wpa;
    logic rej;
    logic overlong;
  } flags_t;

  // input register
  logic              in_v_r;
  logic [7:0]        byte_r;
  logic              last_r;
  logic              mgmt_r;
  logic signed [7:0] sig_in_r;
  logic [3:0]        ch_in_r;

  // frame state
  logic [POS_W-1:0]  pos_r, pos_nxt;
  phase_t            phase_r, phase_nxt;
  logic [7:0]        id_r, id_nxt;
  logic [7:0]        len_r, len_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic              vm_r, vm_nxt;
  name_t             staged_r, staged_nxt;
  name_t             name_r, name_nxt;
  logic [47:0]       addr_r, addr_nxt;
  flags_t            flags_r, flags_nxt;
  logic signed [7:0] sig_r, sig_nxt;
  logic [3:0]        ch_r, ch_nxt;

  logic adv, emit_ok, do_apply, walk_en;
  auth_t auth;

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    vm_nxt     = vm_r;
    staged_nxt = staged_r;
    name_nxt   = name_r;
    addr_nxt   = addr_r;
    flags_nxt  = flags_r;
    sig_nxt    = sig_r;
    ch_nxt     = ch_r;
    do_apply   = 1'b0;

    if (pos_r == '0) begin
      if (!mgmt_r || (byte_r[7:4] != SUB_BEACON && byte_r[7:4] != SUB_PROBE)) begin
        flags_nxt.rej = 1'b1;
      end
      sig_nxt = sig_in_r;
      ch_nxt  = ch_in_r;
    end
    if (pos_r >= MAX_FRAME) begin
      flags_nxt.overlong = 1'b1;
    end

    walk_en = !flags_nxt.overlong && (pos_r >= MIN_FRAME);
    if (!flags_nxt.overlong) begin
      if (pos_r >= ADDR_FIRST && pos_r <= ADDR_LAST) begin
        addr_nxt = {addr_r[39:0], byte_r};
      end
      if (pos_r == PRIV_POS && (byte_r & PRIV_MASK) != 8'd0) begin
        flags_nxt.priv = 1'b1;
      end
    end

    if (walk_en) begin
      case (phase_r)
        PH_ID: begin
          id_nxt    = byte_r;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          len_nxt = byte_r;
          cnt_nxt = 8'd0;
          vm_nxt  = 1'b1;
          if (byte_r == 8'd0) begin
            do_apply  = 1'b1;
            phase_nxt = PH_ID;
          end else begin
            phase_nxt = PH_BODY;
          end
        end
        PH_BODY: begin
          if (cnt_r < 8'(NAME_BYTES)) begin
            staged_nxt[cnt_r[NAME_IDX_W-1:0]] = byte_r;
          end
          if (cnt_r < 8'd4 && byte_r != wpa_oui(cnt_r[1:0])) begin
            vm_nxt = 1'b0;
          end
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt == len_r) begin
            do_apply  = 1'b1;
            phase_nxt = PH_ID;
          end
        end
        default: phase_nxt = PH_ID;
      endcase
    end

    // element takes effect once its body is complete
    if (do_apply) begin
      if (id_nxt == TAG_SSID && len_nxt <= 8'(NAME_BYTES)) begin
        for (int i = 0; i < NAME_BYTES; i++) begin
          if (8'(i) < len_nxt) begin
            name_nxt[i] = staged_nxt[i];
          end
        end
      end else if (id_nxt == TAG_RSN) begin
        flags_nxt.rsn = 1'b1;
      end else if (id_nxt == TAG_VENDOR && len_nxt >= VENDOR_MIN && vm_nxt) begin
        flags_nxt.wpa = 1'b1;
      end
    end

    if (flags_nxt.rsn && flags_nxt.wpa) begin
      auth = AUTH_BOTH;
    end else if (flags_nxt.rsn) begin
      auth = AUTH_WPA2;
    end else if (flags_nxt.wpa) begin
      auth = AUTH_WPA;
    end else if (flags_nxt.priv) begin
      auth = AUTH_WEP;
    end else begin
      auth = AUTH_OPEN;
    end

    emit_ok = !flags_nxt.rej && !flags_nxt.overlong && (pos_r >= LAST_MIN);
    adv     = in_v_r && !(last_r && emit_ok && emit_busy);

    snap.name    = name_nxt;
    snap.addr    = addr_nxt;
    snap.signal  = sig_nxt;
    snap.channel = ch_nxt;
    snap.auth    = auth;

    if (last_r) begin
      pos_nxt   = '0;
      phase_nxt = PH_ID;
      id_nxt    = 8'd0;
      len_nxt   = 8'd0;
      cnt_nxt   = 8'd0;
      vm_nxt    = 1'b0;
      name_nxt  = '0;
      addr_nxt  = '0;
      flags_nxt = '0;
    end else begin
      pos_nxt = (pos_r != POS_MAX) ? pos_r + 12'd1 : pos_r;
    end
  end

  assign snap_load   = adv && last_r && emit_ok;
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      pos_r   <= '0;
      phase_r <= PH_ID;
      id_r    <= 8'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
      vm_r    <= 1'b0;
      name_r  <= '0;
      addr_r  <= '0;
      flags_r <= '0;
      sig_r   <= '0;
      ch_r    <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        in_v_r <= 1'b1;
      end else if (adv) begin
        in_v_r <= 1'b0;
      end
      if (adv) begin
        pos_r   <= pos_nxt;
        phase_r <= phase_nxt;
        id_r    <= id_nxt;
        len_r   <= len_nxt;
        cnt_r   <= cnt_nxt;
        vm_r    <= vm_nxt;
        name_r  <= name_nxt;
        addr_r  <= addr_nxt;
        flags_r <= flags_nxt;
        sig_r   <= sig_nxt;
        ch_r    <= ch_nxt;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r   <= in_ch.data_byte;
      last_r   <= in_ch.frame_end;
      mgmt_r   <= in_ch.mgmt_frame;
      sig_in_r <= in_ch.signal_dbm;
      ch_in_r  <= in_ch.radio_channel;
    end
    if (adv) begin
      staged_r <= staged_nxt;
    end
  end

endmodule

// ===== src/bfip_emitter.sv =====
// Result emitter: holds a frame summary and sends one word per SSID byte.
module bfip_emitter (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            snap_load,
  input  bfip_pkg::snap_t snap,
  output logic            emit_busy,
  bfip_out_if.source      out_ch
);
  import bfip_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t                state_r;
  snap_t                 snap_r;
  logic [NAME_LEN_W-1:0] len_r;
  logic [NAME_IDX_W-1:0] k_r;
  logic                  out_v_r;
  logic [47:0]           addr_o_r;
  logic signed [7:0]     sig_o_r;
  logic [3:0]            ch_o_r;
  logic [2:0]            auth_o_r;
  logic [NAME_LEN_W-1:0] len_o_r;
  logic [NAME_IDX_W-1:0] idx_o_r;
  logic [7:0]            byte_o_r;
  logic                  last_o_r;

  logic out_load, last_item, emit_now;

  assign emit_busy = (state_r != ST_IDLE);
  assign out_load  = !out_v_r || out_ch.ready;
  assign emit_now  = (state_r == ST_EMIT) && out_load;
  assign last_item = (len_r == '0) || (len_r == {1'b0, k_r} + NAME_LEN_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_v_r <= 1'b0;
    end else begin
      if (emit_now) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (snap_load) begin
            snap_r  <= snap;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          len_r   <= name_len(snap_r.name);
          k_r     <= '0;
          state_r <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_load) begin
            addr_o_r <= snap_r.addr;
            sig_o_r  <= snap_r.signal;
            ch_o_r   <= snap_r.channel;
            auth_o_r <= snap_r.auth;
            len_o_r  <= len_r;
            idx_o_r  <= k_r;
            byte_o_r <= (len_r == '0) ? 8'd0 : snap_r.name[k_r];
            last_o_r <= last_item;
            k_r      <= k_r + NAME_IDX_W'(1);
            if (last_item) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.station_addr = addr_o_r;
  assign out_ch.out_signal   = sig_o_r;
  assign out_ch.out_channel  = ch_o_r;
  assign out_ch.auth_class   = auth_o_r;
  assign out_ch.name_length  = len_o_r;
  assign out_ch.name_index   = idx_o_r;
  assign out_ch.name_byte    = byte_o_r;
  assign out_ch.run_last     = last_o_r;

endmodule

// ===== src/beacon_frame_info_parser_core.sv =====
// Top level of the beacon frame info parser: byte parser feeding a result emitter.
// Throughput: one frame byte accepted per cycle; a frame end that yields results waits
//   only while the previous frame's results are still queued in the emitter.
// Result path: input register, emitter summary register, scan state, output register;
//   N results, one per cycle as out ready allows (N = SSID length, or 1 when hidden).
// Reset: synchronous active-low rst_n clears frame state, name buffer and both valids.
module beacon_frame_info_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  bfip_in_if.sink    in_ch,
  bfip_out_if.source out_ch
);
  import bfip_pkg::*;

  // parser -> emitter handoff
  logic  snap_load;
  logic  emit_busy;
  snap_t snap;

  // Parser: registers each incoming byte, tracks position, captures BSSID and
  // privacy, and walks tagged elements. On the frame end byte it presents the
  // finished frame summary and clears its per-frame state.
  bfip_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .emit_busy (emit_busy),
    .snap_load (snap_load),
    .snap      (snap)
  );

  // Emitter: holds the summary, finds the SSID length in its scan state and
  // streams one result word per SSID byte through its output register.
  bfip_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .snap_load (snap_load),
    .snap      (snap),
    .emit_busy (emit_busy),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  // a new summary never overwrites one still being sent
  assert property (@(posedge clk) disable iff (!rst_n) snap_load |-> !emit_busy)
    else $error("frame summary loaded while emitter busy");

  // hidden name gives exactly one blank, final word
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.name_length == 6'd0) |->
      (out_ch.name_index == 5'd0 && out_ch.name_byte == 8'd0 && out_ch.run_last))
    else $error("hidden name result malformed");

  // index stays inside the name, and the last word sits at its end
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.name_length != 6'd0) |->
      ({1'b0, out_ch.name_index} < out_ch.name_length &&
       out_ch.run_last == ({1'b0, out_ch.name_index} + 6'd1 == out_ch.name_length)))
    else $error("name index out of range or run_last misplaced");
`endif

endmodule
